/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* sv/fpse_pkg.sv */
// Constants and types for the binary64 scale / split unit.
// No dependencies.
package fpse_pkg;
    localparam logic FUNC_SCALE = 1'b0;
    localparam logic FUNC_SPLIT = 1'b1;
    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam int EXP_BIAS = 1023;
    localparam int STAGES = 4;

    typedef struct packed {
        logic        func;
        logic        special;
        logic        sign;
        logic [63:0] bits;
        logic [52:0] sig;
        logic [12:0] e;      // unbiased exponent, signed
        logic signed [31:0] scale;
    } fpse_s1_t;
endpackage

/* sv/fp64_scale_and_split_exponent_unit.sv */
// Top level of the binary64 scale (ldexp) and split (frexp) unit.
// Depends on fpse_pkg and assert_macros.svh.
//
//  channel | signals                              | handshake
//  input   | func, operand_bits, exp_in           | in_valid / in_ready
//  output  | result_bits, exp_out                 | out_valid / out_ready
//
// Four register stages: decode and leading-zero count, normalize and exponent
// sum, classify and denormal shift, round/pack. One word enters per cycle
// while in_ready is high. Reset clears only the stage valid bits. A stall
// holds every stage whose successor is full and held; bubbles are squeezed
// out, nothing is lost or repeated.
`include "assert_macros.svh"
module fp64_scale_and_split_exponent_unit
    import fpse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [63:0]        operand_bits,
    input  logic signed [31:0] exp_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        result_bits,
    output logic signed [11:0] exp_out
);
    localparam logic [1:0] CLS_NORMAL   = 2'd0;
    localparam logic [1:0] CLS_OVERFLOW = 2'd1;
    localparam logic [1:0] CLS_ZERO     = 2'd2;
    localparam logic [1:0] CLS_DENORM   = 2'd3;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] adv;

    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end
    assign in_ready = adv[0];
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1: decode, leading-zero count of the fraction
    logic        func1_reg, spec1_reg;
    logic [63:0] bits1_reg;
    logic signed [31:0] scale1_reg;
    logic [5:0]  lz;
    logic [5:0]  lz1_reg;
    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 52; i++)
        begin
            if (operand_bits[i])
            begin
                lz = 6'(51 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            func1_reg  <= func;
            bits1_reg  <= operand_bits;
            scale1_reg <= exp_in;
            lz1_reg    <= lz;
            spec1_reg  <= (operand_bits[62:52] == EXP_ALL_ONES)
                       || (operand_bits[62:0] == 63'd0);
        end
    end

    // stage 2: normalize denormals, exponent sum
    logic [51:0] m1;
    logic [52:0] sig2_next;
    logic [12:0] e2_next;
    logic signed [33:0] t2_next;
    logic signed [33:0] t2_reg;
    assign m1 = bits1_reg[51:0];
    always_comb
    begin
        if (bits1_reg[62:52] == 11'd0)
        begin
            // shift so the leading one lands on the hidden bit
            sig2_next = {1'b0, m1} << (lz1_reg + 6'd1);
            e2_next   = 13'(-1023) - 13'(lz1_reg);
        end
        else
        begin
            sig2_next = {1'b1, m1};
            e2_next   = 13'({2'b00, bits1_reg[62:52]}) - 13'(EXP_BIAS);
        end
    end
    assign t2_next = 34'(signed'(e2_next)) + 34'(scale1_reg);

    fpse_s1_t s2_reg;
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_reg.func    <= func1_reg;
            s2_reg.special <= spec1_reg;
            s2_reg.sign    <= bits1_reg[63];
            s2_reg.bits    <= bits1_reg;
            s2_reg.scale   <= scale1_reg;
            s2_reg.sig     <= sig2_next;
            s2_reg.e       <= e2_next;
            t2_reg         <= t2_next;
        end
    end

    // stage 3: classify, denormal shift
    logic        func3_reg, spec3_reg, sign3_reg;
    logic [63:0] bits3_reg;
    logic [52:0] sig3_reg;
    logic [12:0] e3_reg;
    logic [1:0]  cls3_reg;
    logic [52:0] q3_reg;
    logic        gt3_reg, eq3_reg;
    logic [5:0]  s_amt;
    logic [52:0] mask, half, rem;
    assign s_amt = 6'(-34'sd1022 - t2_reg);
    assign mask  = (53'd1 << s_amt) - 53'd1;
    assign half  = 53'd1 << (s_amt - 6'd1);
    assign rem   = s2_reg.sig & mask;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            func3_reg <= s2_reg.func;
            spec3_reg <= s2_reg.special;
            sign3_reg <= s2_reg.sign;
            bits3_reg <= s2_reg.bits;
            sig3_reg  <= s2_reg.sig;
            // frexp exponent kept in e3 when splitting
            e3_reg    <= (s2_reg.func == FUNC_SPLIT) ? s2_reg.e + 13'd1
                                                     : 13'(t2_reg + 34'sd1023);
            q3_reg    <= s2_reg.sig >> s_amt;
            gt3_reg   <= rem > half;
            eq3_reg   <= rem == half;
            if (t2_reg > 34'sd1023)
            begin
                cls3_reg <= CLS_OVERFLOW;
            end
            else if (t2_reg >= -34'sd1022)
            begin
                cls3_reg <= CLS_NORMAL;
            end
            else if (t2_reg < -34'sd1075)
            begin
                cls3_reg <= CLS_ZERO;
            end
            else
            begin
                cls3_reg <= CLS_DENORM;
            end
        end
    end

    // stage 4: round and pack
    logic [63:0] res;
    logic [11:0] eo;
    logic [52:0] qr;
    assign qr = q3_reg + 53'((gt3_reg || (eq3_reg && q3_reg[0])) ? 1 : 0);
    always_comb
    begin
        eo = 12'd0;
        if (spec3_reg)
        begin
            res = bits3_reg;
        end
        else if (func3_reg == FUNC_SPLIT)
        begin
            res = {sign3_reg, 11'(EXP_BIAS - 1), sig3_reg[51:0]};
            eo  = e3_reg[11:0];
        end
        else
        begin
            unique case (cls3_reg)
                CLS_NORMAL:   res = {sign3_reg, e3_reg[10:0], sig3_reg[51:0]};
                CLS_OVERFLOW: res = {sign3_reg, EXP_ALL_ONES, 52'd0};
                CLS_ZERO:     res = {sign3_reg, 63'd0};
                CLS_DENORM:   res = {sign3_reg, 10'd0, qr};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            result_bits <= res;
            exp_out     <= eo;
        end
    end

    `ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(result_bits))
    `ASSERT_CLK(a_ready, clk, rst_n, out_ready |-> in_ready)
    `ASSERT_NEXT(a_scale_exp0, clk, rst_n, adv[3] && v_reg[2] && func3_reg == FUNC_SCALE,
                 exp_out == 12'sd0)
endmodule
